// ===== hw/rtl/mwma_pkg.sv =====
// Package for the masked window max average block.
// Holds the register index codes, the fixed widths and the controller state type.
// Used by mwma_div and masked_window_max_average.
`default_nettype none
package mwma_pkg;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd2;
    localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;
    localparam int AVG_BITS      = 16;
    localparam int PROB_BITS     = 16;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_WIN   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;
endpackage
`default_nettype wire

// ===== hw/rtl/mwma_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on mwma_pkg for the quotient width.
`default_nettype none
module mwma_div #(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 17
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    output logic                     o_done,
    output logic [15:0]              o_quot
);
    import mwma_pkg::*;
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_num;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS-1:0] r_rem;
    logic [AVG_BITS-1:0] r_quot;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_BITS:0]   w_trial;
    logic [DEN_BITS+1:0] w_diff;

    // Shift in the next numerator bit and try one subtraction.
    assign w_trial = {r_rem, r_num[NUM_BITS-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            if (!w_diff[DEN_BITS+1]) begin
                r_rem  <= w_diff[DEN_BITS-1:0];
                r_quot <= {r_quot[AVG_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial[DEN_BITS-1:0];
                r_quot <= {r_quot[AVG_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// ===== hw/rtl/masked_window_max_average.sv =====
// Top level of the masked window max average block.
// Depends on mwma_pkg and instantiates mwma_div.
//
// Usage: pixels of a probability map enter in raster order on the slave
// stream (s_axis_*). tdata carries prob in bits 15:0; tuser carries the
// inside flag. Pixels outside the region count as zero. Once per frame,
// on its last pixel, one item leaves on the master stream (m_axis_*) with
// the best window average, the window-found flag and the no-inside flag.
// Each pixel passes the steps accept, memory read, column update with
// line-store write and window update before the next one is taken; the
// registered memory reads and the read of the leaving column need these
// steps. After the last pixel is accepted, the result passes the remaining
// pixel steps, the choice of division, the divider start, the divide and
// the capture of the quotient; the divide is skipped when no pixel was inside.
// A stalled receiver holds the result in the output register; no new pixel
// is taken until it leaves.
// Reset restores the register defaults (256x256 image, 8x8 window) and
// starts a fresh frame at pixel (0,0). Any configuration write also starts
// a fresh frame. Column sums and inside counts are rebuilt on row 0 of every
// frame, so no clearing pass is needed; the line store is only read for rows
// written earlier in the same frame.
// The running window needs no delay line: the column sum leaving the window
// is read back from the column memory at column x - window_width.
`default_nettype none
module masked_window_max_average #(
    parameter int MAX_WIDTH         = 256,
    parameter int MAX_HEIGHT        = 256,
    parameter int MAX_WINDOW_HEIGHT = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] prob
    input  wire logic        s_axis_tuser,   // [0] inside_req
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] best_average
    output logic [1:0]       m_axis_tuser,   // [0] window_found, [1] no_inside
    input  wire logic        i_cfg_we,
    input  wire logic [mwma_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [mwma_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import mwma_pkg::*;

    localparam int XB   = $clog2(MAX_WIDTH);
    localparam int YB   = $clog2(MAX_HEIGHT);
    localparam int WB   = $clog2(MAX_WIDTH + 1);
    localparam int HB   = $clog2(MAX_HEIGHT + 1);
    localparam int WHB  = $clog2(MAX_WINDOW_HEIGHT + 1);
    localparam int RB   = (MAX_WINDOW_HEIGHT > 1) ? $clog2(MAX_WINDOW_HEIGHT) : 1;
    localparam int CSB  = PROB_BITS + WHB;
    localparam int CCB  = WHB;
    localparam int AB   = WB + WHB;
    localparam int RSB  = CSB + WB;
    localparam int TSB  = PROB_BITS + XB + YB;
    localparam int TIB  = XB + YB + 1;
    localparam int SDEP = MAX_WINDOW_HEIGHT * MAX_WIDTH;
    localparam int SAB  = $clog2(SDEP);
    localparam int DNB  = (TSB > RSB) ? TSB : RSB;
    localparam int DDB  = (TIB > AB) ? TIB : AB;

    // Configuration registers.
    logic [8:0] r_img_w, r_img_h, r_win_w;
    logic [6:0] r_win_h;
    logic       w_restart;
    assign w_restart = i_cfg_we && (i_cfg_idx == REG_IMAGE_WIDTH ||
        i_cfg_idx == REG_IMAGE_HEIGHT || i_cfg_idx == REG_WINDOW_WIDTH ||
        i_cfg_idx == REG_WINDOW_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 9'd256;
            r_img_h <= 9'd256;
            r_win_w <= 9'd8;
            r_win_h <= 7'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:   r_img_w <= i_cfg_data;
                REG_IMAGE_HEIGHT:  r_img_h <= i_cfg_data;
                REG_WINDOW_WIDTH:  r_win_w <= i_cfg_data;
                REG_WINDOW_HEIGHT: r_win_h <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Effective sizes after clamping.
    logic [WB-1:0]  w_w, w_ww;
    logic [HB-1:0]  w_h;
    logic [WHB-1:0] w_wh;
    logic [HB-1:0]  w_wh0;
    always_comb begin
        if (r_img_w == 9'd0) w_w = WB'(1);
        else if (32'(r_img_w) > MAX_WIDTH) w_w = WB'(MAX_WIDTH);
        else w_w = WB'(r_img_w);
        if (r_img_h == 9'd0) w_h = HB'(1);
        else if (32'(r_img_h) > MAX_HEIGHT) w_h = HB'(MAX_HEIGHT);
        else w_h = HB'(r_img_h);
        if (r_win_w == 9'd0) w_ww = WB'(1);
        else if (32'(r_win_w) > 32'(w_w)) w_ww = w_w;
        else w_ww = WB'(r_win_w);
        if (r_win_h == 7'd0) w_wh0 = HB'(1);
        else if (32'(r_win_h) > MAX_WINDOW_HEIGHT) w_wh0 = HB'(MAX_WINDOW_HEIGHT);
        else w_wh0 = HB'(r_win_h);
        if (32'(w_wh0) > 32'(w_h)) w_wh = WHB'(w_h);
        else w_wh = WHB'(w_wh0);
    end

    // Memories: line store and column sums with inside counts.
    logic [PROB_BITS:0]    m_store [SDEP];
    logic [CSB+CCB-1:0]    m_col   [MAX_WIDTH];
    logic [PROB_BITS:0]    r_store_q;
    logic [CSB+CCB-1:0]    r_col_q;
    logic [SAB-1:0]        w_store_addr;
    logic [XB-1:0]         w_col_raddr;
    logic                  w_store_we, w_col_we;
    logic [CSB+CCB-1:0]    w_col_wdata;

    // Frame state.
    t_state          r_state;
    logic [XB-1:0]   r_x;
    logic [YB-1:0]   r_y;
    logic [RB-1:0]   r_slot_row;
    logic [PROB_BITS-1:0] r_p;
    logic            r_in;
    logic [RSB-1:0]  r_rsum;
    logic [AB-1:0]   r_rcnt;
    logic [RSB-1:0]  r_best;
    logic            r_found;
    logic [TSB-1:0]  r_tsum;
    logic [TIB-1:0]  r_tin;
    logic [CSB-1:0]  r_new_sum;
    logic [CCB-1:0]  r_new_cnt;
    logic            r_last;
    logic            r_found_o, r_noin_o;
    logic [15:0]     r_avg;
    logic            r_ovalid;
    logic            r_div_start;
    logic [DNB-1:0]  r_div_num;
    logic [DDB-1:0]  r_div_den;
    logic            w_div_done;
    logic [15:0]     w_div_q;

    always_ff @(posedge i_clk) begin
        if (w_store_we) m_store[w_store_addr] <= {r_in, r_p};
        r_store_q <= m_store[w_store_addr];
    end
    always_ff @(posedge i_clk) begin
        if (w_col_we) m_col[r_x] <= w_col_wdata;
        r_col_q <= m_col[w_col_raddr];
    end

    logic w_take;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign w_take = s_axis_tvalid && s_axis_tready;

    // Address selection: store slot for this pixel; column read is x during
    // READ and x - ww (leaving column) during WIN.
    logic [XB-1:0] w_x_in;
    assign w_x_in = r_x;
    assign w_store_addr = SAB'(32'(r_slot_row) * MAX_WIDTH + 32'(w_x_in));
    assign w_col_raddr = (r_state == ST_WIN) ? XB'(32'(r_x) - 32'(w_ww))
                                             : w_x_in;
    assign w_store_we = (r_state == ST_WIN);
    assign w_col_we   = (r_state == ST_WIN);

    // Column update from the read data (valid in the WIN state).
    logic [CSB-1:0] w_cs;
    logic [CCB-1:0] w_cc;
    logic           w_y_zero, w_y_ge;
    assign w_y_zero = (r_y == '0);
    assign w_y_ge   = 32'(r_y) >= 32'(w_wh);
    always_comb begin
        w_cs = r_col_q[CSB-1:0];
        w_cc = r_col_q[CSB+CCB-1:CSB];
        if (w_y_zero) begin
            w_cs = '0;
            w_cc = '0;
        end else if (w_y_ge) begin
            w_cs = w_cs - CSB'(r_store_q[PROB_BITS-1:0]);
            w_cc = w_cc - CCB'(r_store_q[PROB_BITS]);
        end
        w_cs = w_cs + CSB'(r_p);
        w_cc = w_cc + CCB'(r_in);
    end
    // The updated column goes back to memory in the same WIN cycle.
    assign w_col_wdata = {w_cc, w_cs};

    // Window update, in the cycle after the column write.
    logic [RSB-1:0] w_rs;
    logic [AB-1:0]  w_rc;
    logic           w_x_ge, w_qual;
    assign w_x_ge = 32'(r_x) >= 32'(w_ww);
    always_comb begin
        w_rs = (r_x == '0) ? '0 : r_rsum;
        w_rc = (r_x == '0) ? '0 : r_rcnt;
        w_rs = w_rs + RSB'(r_new_sum);
        w_rc = w_rc + AB'(r_new_cnt);
        if (w_x_ge) begin
            w_rs = w_rs - RSB'(r_col_q[CSB-1:0]);
            w_rc = w_rc - AB'(r_col_q[CSB+CCB-1:CSB]);
        end
    end
    logic [AB-1:0] r_area;
    always_ff @(posedge i_clk) r_area <= AB'(32'(w_ww) * 32'(w_wh));
    assign w_qual = (32'(r_x) + 1 >= 32'(w_ww)) && (32'(r_y) + 1 >= 32'(w_wh))
                    && (w_rc == r_area);

    logic w_last_x, w_last_y;
    assign w_last_x = 32'(r_x) + 1 >= 32'(w_w);
    assign w_last_y = 32'(r_y) + 1 >= 32'(w_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_state     <= ST_IDLE;
            r_x         <= '0;
            r_y         <= '0;
            r_slot_row  <= '0;
            r_rsum      <= '0;
            r_rcnt      <= '0;
            r_best      <= '0;
            r_found     <= 1'b0;
            r_tsum      <= '0;
            r_tin       <= '0;
            r_div_start <= 1'b0;
            if (!i_rst_n) r_ovalid <= 1'b0;
        end else begin
            // The divider starts in the cycle after the division is chosen,
            // unless no pixel was inside.
            r_div_start <= (r_state == ST_OUT) && r_last && (r_found || (r_tin != '0));
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (w_take) begin
                    r_p     <= s_axis_tuser ? s_axis_tdata[PROB_BITS-1:0] : '0;
                    r_in    <= s_axis_tuser;
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    // Memory reads of store slot and column x are in flight.
                    r_state <= ST_WIN;
                end
                ST_WIN: begin
                    r_new_sum <= w_cs;
                    r_new_cnt <= w_cc;
                    r_tsum    <= r_tsum + TSB'(r_p);
                    r_tin     <= r_tin + TIB'(r_in);
                    r_state   <= ST_DIV;
                end
                ST_DIV: begin
                    // Window step; the leaving column came back from the read.
                    r_rsum <= w_rs;
                    r_rcnt <= w_rc;
                    if (w_qual) begin
                        r_found <= 1'b1;
                        if (w_rs > r_best) r_best <= w_rs;
                    end
                    r_last <= w_last_x && w_last_y;
                    if (!w_last_x) begin
                        r_x <= r_x + 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_x <= '0;
                        if (!w_last_y) begin
                            r_y <= r_y + 1'b1;
                            r_slot_row <= (32'(r_slot_row) + 1 >= 32'(w_wh))
                                          ? '0 : r_slot_row + 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (r_last) begin
                        // First cycle: choose the division, or give a zero result at once when no pixel was inside.
                        r_found_o <= r_found;
                        r_noin_o  <= !r_found && (r_tin == '0);
                        r_div_num <= r_found ? DNB'(r_best) : DNB'(r_tsum);
                        r_div_den <= r_found ? DDB'(r_area) : DDB'(r_tin);
                        r_last <= 1'b0;
                        if (!r_found && r_tin == '0) begin
                            r_avg   <= '0;
                            r_ovalid <= 1'b1;
                            r_state <= ST_IDLE;
                            r_x <= '0; r_y <= '0; r_slot_row <= '0;
                            r_rsum <= '0; r_rcnt <= '0; r_best <= '0;
                            r_found <= 1'b0; r_tsum <= '0; r_tin <= '0;
                        end
                    end else if (w_div_done) begin
                        r_avg    <= w_div_q;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                        r_x <= '0; r_y <= '0; r_slot_row <= '0;
                        r_rsum <= '0; r_rcnt <= '0; r_best <= '0;
                        r_found <= 1'b0; r_tsum <= '0; r_tin <= '0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    mwma_div #(.NUM_BITS(DNB), .DEN_BITS(DDB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_avg;
    assign m_axis_tuser  = {r_noin_o, r_found_o};

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready) else $error("pixel taken while result held");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !(r_found_o && r_noin_o)) else $error("conflicting flags");
    a_noin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_noin_o) |-> (r_avg == '0)) else $error("no-inside not zero");
endmodule
`default_nettype wire

// ===== tb/tb_masked_window_max_average.sv =====
// Testbench for masked_window_max_average: streams probability frames in raster order.
// Each result is checked against an in-bench model of the windowed maximum search, or against a directed row's value.
// Depends on mwma_pkg and the masked_window_max_average RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_masked_window_max_average;
    import mwma_pkg::*;

    typedef struct packed {
        logic [15:0] avg;
        logic        found;
        logic        none_in;
    } frame_result_t;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

    typedef struct {
        row_kind_e     kind;
        logic [1:0]    idx;
        logic [15:0]   val;
        logic          ins;
        logic          has_exp;
        frame_result_t exp;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] prob
    logic        s_axis_tuser;   // [0] inside_req
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] best_average
    logic [1:0]  m_axis_tuser;   // [0] window_found, [1] no_inside
    logic        i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    masked_window_max_average DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Expected frame results, oldest first.
    frame_result_t avg_q[$];
    int  n_errors   = 0;
    int  n_pixels   = 0;
    bit  idle_on    = 1'b1;
    bit  hold_req   = 1'b0;

    // Model state: registers, line store, column sums and the frame search.
    bit [8:0]        reg_img_w, reg_img_h, reg_win_w;
    bit [6:0]        reg_win_h;
    bit [16:0]       line_mem [64*256];
    longint unsigned col_sum [256];
    int unsigned     col_cnt [256];
    longint unsigned win_sum, best_win, frame_sum;
    int unsigned     win_cnt, frame_inside, cur_x, cur_y;
    bit              any_window;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("masked_window_max_average: mismatch");
        $finish;
    end

    function automatic int unsigned clampv(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned eff_w();
        return clampv(reg_img_w, 256);
    endfunction

    function automatic int unsigned eff_h();
        return clampv(reg_img_h, 256);
    endfunction

    function automatic void frame_clear();
        win_sum = 0; win_cnt = 0; best_win = 0; any_window = 0;
        frame_sum = 0; frame_inside = 0; cur_x = 0; cur_y = 0;
    endfunction

    function automatic void reg_apply(logic [1:0] idx, logic [8:0] val);
        case (idx)
            REG_IMAGE_WIDTH:   reg_img_w = val;
            REG_IMAGE_HEIGHT:  reg_img_h = val;
            REG_WINDOW_WIDTH:  reg_win_w = val;
            REG_WINDOW_HEIGHT: reg_win_h = val[6:0];
            default: ;
        endcase
        frame_clear();
    endfunction

    // Advances the model by one pixel; returns 1 with the result on the last
    // pixel of a frame.
    function automatic bit window_search_step(logic [15:0] prob, logic ins,
                                              output frame_result_t r);
        int unsigned w, h, ww, wh, x, y, slot;
        longint unsigned p;
        w  = eff_w();
        h  = eff_h();
        ww = clampv(reg_win_w, w);
        wh = clampv(clampv(reg_win_h, 64), h);
        x  = (cur_x >= w) ? w - 1 : cur_x;
        y  = (cur_y >= h) ? h - 1 : cur_y;
        p  = ins ? prob : 0;
        slot = (y % wh) * 256 + x;
        r = '0;
        if (y == 0) begin
            col_sum[x] = 0;
            col_cnt[x] = 0;
        end else if (y >= wh) begin
            col_sum[x] -= line_mem[slot][15:0];
            col_cnt[x] -= line_mem[slot][16];
        end
        line_mem[slot] = {ins, p[15:0]};
        col_sum[x] += p;
        col_cnt[x] += ins;
        frame_sum += p;
        frame_inside += ins;
        if (x == 0) begin
            win_sum = 0;
            win_cnt = 0;
        end
        win_sum += col_sum[x];
        win_cnt += col_cnt[x];
        if (x >= ww) begin
            win_sum -= col_sum[x - ww];
            win_cnt -= col_cnt[x - ww];
        end
        if (x + 1 >= ww && y + 1 >= wh && win_cnt == ww * wh) begin
            any_window = 1;
            if (win_sum > best_win) best_win = win_sum;
        end
        if (x + 1 < w) begin
            cur_x = x + 1;
            return 0;
        end
        cur_x = 0;
        if (y + 1 < h) begin
            cur_y = y + 1;
            return 0;
        end
        if (any_window) begin
            r.avg = 16'(best_win / (ww * wh));
            r.found = 1;
        end else if (frame_inside != 0) begin
            r.avg = 16'(frame_sum / frame_inside);
        end else begin
            r.none_in = 1;
        end
        frame_clear();
        return 1;
    endfunction

    task automatic report_mismatch(string what);
        n_errors++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Waits until every expected result has left, then lets the pipeline
    // drain the pixels that produce no result.
    task automatic wait_quiet();
        while (avg_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Stops offering pixels, waits for the block to go quiet, then writes.
    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        s_axis_tvalid <= 1'b0;
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reg_apply(idx, val);
    endtask

    // Offers one pixel and waits for it to be taken. Known results override
    // the model's guess for directed rows.
    task automatic send_pixel(logic [15:0] prob, logic ins, logic has_exp,
                              frame_result_t exp);
        frame_result_t r;
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= prob;
        s_axis_tuser  <= ins;
        do @(posedge i_clk); while (!s_axis_tready);
        n_pixels++;
        if (window_search_step(prob, ins, r)) begin
            avg_q.push_back(has_exp ? exp : r);
        end
    endtask

    function automatic logic [15:0] pick_prob();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(16'hFF00 + $urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Sends a frame, or a part of one. Most frames are mostly inside so that
    // whole windows occur; the rest are all outside or mix inside and outside pixels freely.
    task automatic send_frame(int unsigned npix);
        int unsigned k, mode;
        logic ins;
        mode = $urandom_range(0, 9);
        for (k = 0; k < npix; k++) begin
            case (mode)
                0, 1, 2, 3: ins = 1'b1;
                4, 5, 6:    ins = ($urandom_range(0, 15) != 0);
                7:          ins = 1'b0;
                default:    ins = 1'($urandom_range(0, 1));
            endcase
            send_pixel(pick_prob(), ins, 1'b0, '0);
        end
    endtask

    // Receiver: checks each result and stalls in random bursts, once for a
    // long stretch so that the block holds its result and stops taking pixels.
    initial begin : receiver
        int stall_left;
        frame_result_t got, want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{avg: m_axis_tdata, found: m_axis_tuser[0],
                        none_in: m_axis_tuser[1]};
                if (avg_q.size() == 0) begin
                    report_mismatch("result with none expected");
                end else begin
                    want = avg_q.pop_front();
                    if (got.avg != want.avg)
                        report_mismatch($sformatf("best_average %h, expected %h",
                                                  got.avg, want.avg));
                    if (got.found != want.found)
                        report_mismatch($sformatf("window_found %b, expected %b",
                                                  got.found, want.found));
                    if (got.none_in != want.none_in)
                        report_mismatch($sformatf("no_inside %b, expected %b",
                                                  got.none_in, want.none_in));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 399;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 17);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Directed rows. Expected values are given where they are obvious.
    stim_row_t dir_rows[] = '{
        '{ROW_CFG, REG_IMAGE_WIDTH,   16'd1, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_IMAGE_HEIGHT,  16'd1, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_WINDOW_WIDTH,  16'd1, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_WINDOW_HEIGHT, 16'd1, 1'b0, 1'b0, '0},
        '{ROW_PIX, 2'd0, 16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
        '{ROW_PIX, 2'd0, 16'h1234, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b1}},
        '{ROW_PIX, 2'd0, 16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b0}},
        // A zero window width acts as one.
        '{ROW_CFG, REG_WINDOW_WIDTH,  16'd0, 1'b0, 1'b0, '0},
        '{ROW_PIX, 2'd0, 16'h8000, 1'b1, 1'b1, '{16'h8000, 1'b1, 1'b0}},
        // Two-pixel row with a two-wide window: one pixel outside means no
        // window, so the inside average is reported.
        '{ROW_CFG, REG_IMAGE_WIDTH,   16'd2, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_WINDOW_WIDTH,  16'd2, 1'b0, 1'b0, '0},
        '{ROW_PIX, 2'd0, 16'h1234, 1'b1, 1'b0, '0},
        '{ROW_PIX, 2'd0, 16'hFFFF, 1'b0, 1'b1, '{16'h1234, 1'b0, 1'b0}},
        // Zero image width, oversize window height clamped to the image.
        '{ROW_CFG, REG_IMAGE_WIDTH,   16'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_IMAGE_HEIGHT,  16'd3, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_WINDOW_HEIGHT, 16'd127, 1'b0, 1'b0, '0},
        '{ROW_PIX, 2'd0, 16'd3, 1'b1, 1'b0, '0},
        '{ROW_PIX, 2'd0, 16'd4, 1'b1, 1'b0, '0},
        '{ROW_PIX, 2'd0, 16'd6, 1'b1, 1'b0, '0},
        // Oversize image width with a one-row image and full-width window.
        '{ROW_CFG, REG_IMAGE_WIDTH,   16'd511, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_IMAGE_HEIGHT,  16'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_WINDOW_WIDTH,  16'd511, 1'b0, 1'b0, '0}
    };

    initial begin : stimulus
        int sel;
        int unsigned npix;
        bit did_hold;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        did_hold      = 1'b0;
        reg_img_w = 9'd256; reg_img_h = 9'd256; reg_win_w = 9'd8; reg_win_h = 7'd8;
        frame_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].val[8:0]);
            else
                send_pixel(dir_rows[i].val, dir_rows[i].ins,
                           dir_rows[i].has_exp, dir_rows[i].exp);
        end
        send_frame(eff_w() * eff_h());

        // Random phases: a new setting, then a few frames. Small images keep
        // results frequent; some phases take the largest sizes along one axis.
        while (n_pixels < 850) begin
            if (n_pixels > 700) idle_on = 1'b0;
            sel = $urandom_range(0, 9);
            case (sel)
                0: begin
                    write_reg(REG_IMAGE_WIDTH, 9'($urandom_range(256, 511)));
                    write_reg(REG_IMAGE_HEIGHT, 9'($urandom_range(0, 1)));
                    write_reg(REG_WINDOW_WIDTH, 9'($urandom_range(1, 511)));
                    write_reg(REG_WINDOW_HEIGHT, 9'($urandom_range(0, 127)));
                end
                1: begin
                    write_reg(REG_IMAGE_WIDTH, 9'($urandom_range(0, 1)));
                    write_reg(REG_IMAGE_HEIGHT, 9'($urandom_range(64, 511)));
                    write_reg(REG_WINDOW_WIDTH, 9'($urandom_range(0, 511)));
                    write_reg(REG_WINDOW_HEIGHT, 9'($urandom_range(60, 127)));
                end
                default: begin
                    write_reg(REG_IMAGE_WIDTH, 9'($urandom_range(0, 9)));
                    write_reg(REG_IMAGE_HEIGHT, 9'($urandom_range(0, 9)));
                    write_reg(REG_WINDOW_WIDTH, 9'($urandom_range(0, 11)));
                    write_reg(REG_WINDOW_HEIGHT, 9'($urandom_range(0, 11)));
                end
            endcase
            npix = eff_w() * eff_h();
            // The long hold lands on a run of small frames so that pixels
            // back up behind a pending result.
            if (!did_hold && n_pixels > 300 && npix < 40) begin
                did_hold = 1'b1;
                hold_req = 1'b1;
            end
            repeat ((npix > 64) ? 1 : $urandom_range(1, 4)) send_frame(npix);
            // Now and then a partial frame, abandoned by a register write.
            if ($urandom_range(0, 5) == 0 && npix > 1) begin
                send_frame($urandom_range(1, npix - 1));
                write_reg(2'($urandom_range(0, 3)), 9'($urandom_range(0, 9)));
                send_frame(eff_w() * eff_h());
            end
        end
        s_axis_tvalid <= 1'b0;

        while (avg_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0)
            $display("masked_window_max_average: match");
        else
            $display("masked_window_max_average: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
